FILE: rtl/rv32enc_pkg.sv
// Shared types, opcode constants, the instruction table and a word-packing helper.
package rv32enc_pkg;

  // Major opcodes of the RV32IM base encoding.
  localparam logic [6:0] OP_OP     = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  // Rounding term that splits an address into a hi/lo pair.
  localparam logic [31:0] HI_ROUND = 32'h0000_0800;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;

  typedef enum logic [5:0] {
    K_ADD, K_SUB, K_XOR, K_OR, K_AND, K_SLL, K_SRL, K_SRA, K_SLT, K_SLTU,
    K_MUL, K_MULH, K_DIV, K_REM,
    K_ADDI, K_XORI, K_ORI, K_ANDI, K_SLLI, K_SRLI, K_SRAI, K_SLTI, K_SLTIU,
    K_LB, K_LH, K_LW, K_LBU, K_LHU, K_JALR, K_ECALL, K_EBREAK,
    K_SB, K_SH, K_SW,
    K_BEQ, K_BNE, K_BLT, K_BGE, K_BLTU, K_BGEU,
    K_LUI, K_AUIPC, K_JAL,
    K_BEQZ, K_BNEZ, K_LI, K_MV, K_J, K_JR, K_JAL_RA, K_JALR_RA, K_LW_SYM
  } kind_t;

  typedef enum logic [3:0] {
    CL_R, CL_IA, CL_ILW, CL_ISH, CL_SYS, CL_S, CL_B, CL_U, CL_J
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [6:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
  } row_t;

  function automatic row_t row_of(kind_t k);
    row_t r;
    r = '{cls: CL_R, op: OP_OP, f3: 3'd0, f7: 7'h00};
    case (k)
      K_ADD:    r = '{CL_R,   OP_OP,     3'd0, 7'h00};
      K_SUB:    r = '{CL_R,   OP_OP,     3'd0, 7'h20};
      K_XOR:    r = '{CL_R,   OP_OP,     3'd4, 7'h00};
      K_OR:     r = '{CL_R,   OP_OP,     3'd6, 7'h00};
      K_AND:    r = '{CL_R,   OP_OP,     3'd7, 7'h00};
      K_SLL:    r = '{CL_R,   OP_OP,     3'd1, 7'h00};
      K_SRL:    r = '{CL_R,   OP_OP,     3'd5, 7'h00};
      K_SRA:    r = '{CL_R,   OP_OP,     3'd5, 7'h20};
      K_SLT:    r = '{CL_R,   OP_OP,     3'd2, 7'h00};
      K_SLTU:   r = '{CL_R,   OP_OP,     3'd3, 7'h00};
      K_MUL:    r = '{CL_R,   OP_OP,     3'd0, 7'h01};
      K_MULH:   r = '{CL_R,   OP_OP,     3'd1, 7'h01};
      K_DIV:    r = '{CL_R,   OP_OP,     3'd4, 7'h01};
      K_REM:    r = '{CL_R,   OP_OP,     3'd6, 7'h01};
      K_ADDI:   r = '{CL_IA,  OP_IMM,    3'd0, 7'h00};
      K_XORI:   r = '{CL_IA,  OP_IMM,    3'd4, 7'h00};
      K_ORI:    r = '{CL_IA,  OP_IMM,    3'd6, 7'h00};
      K_ANDI:   r = '{CL_IA,  OP_IMM,    3'd7, 7'h00};
      K_SLLI:   r = '{CL_ISH, OP_IMM,    3'd1, 7'h00};
      K_SRLI:   r = '{CL_ISH, OP_IMM,    3'd5, 7'h00};
      K_SRAI:   r = '{CL_ISH, OP_IMM,    3'd5, 7'h20};
      K_SLTI:   r = '{CL_IA,  OP_IMM,    3'd2, 7'h00};
      K_SLTIU:  r = '{CL_IA,  OP_IMM,    3'd3, 7'h00};
      K_LB:     r = '{CL_IA,  OP_LOAD,   3'd0, 7'h00};
      K_LH:     r = '{CL_IA,  OP_LOAD,   3'd1, 7'h00};
      K_LW:     r = '{CL_ILW, OP_LOAD,   3'd2, 7'h00};
      K_LBU:    r = '{CL_IA,  OP_LOAD,   3'd4, 7'h00};
      K_LHU:    r = '{CL_IA,  OP_LOAD,   3'd5, 7'h00};
      K_JALR:   r = '{CL_IA,  OP_JALR,   3'd0, 7'h00};
      K_ECALL:  r = '{CL_SYS, OP_SYSTEM, 3'd0, 7'h00};
      K_EBREAK: r = '{CL_SYS, OP_SYSTEM, 3'd0, 7'h01};
      K_SB:     r = '{CL_S,   OP_STORE,  3'd0, 7'h00};
      K_SH:     r = '{CL_S,   OP_STORE,  3'd1, 7'h00};
      K_SW:     r = '{CL_S,   OP_STORE,  3'd2, 7'h00};
      K_BEQ:    r = '{CL_B,   OP_BRANCH, 3'd0, 7'h00};
      K_BNE:    r = '{CL_B,   OP_BRANCH, 3'd1, 7'h00};
      K_BLT:    r = '{CL_B,   OP_BRANCH, 3'd4, 7'h00};
      K_BGE:    r = '{CL_B,   OP_BRANCH, 3'd5, 7'h00};
      K_BLTU:   r = '{CL_B,   OP_BRANCH, 3'd6, 7'h00};
      K_BGEU:   r = '{CL_B,   OP_BRANCH, 3'd7, 7'h00};
      K_LUI:    r = '{CL_U,   OP_LUI,    3'd0, 7'h00};
      K_AUIPC:  r = '{CL_U,   OP_AUIPC,  3'd0, 7'h00};
      K_JAL:    r = '{CL_J,   OP_JAL,    3'd0, 7'h00};
      default:  r = '{CL_R,   OP_OP,     3'd0, 7'h00};
    endcase
    return r;
  endfunction

  function automatic logic [31:0] i_word(logic [11:0] f12, logic [4:0] rs1, logic [2:0] f3,
                                         logic [4:0] rd, logic [6:0] op);
    return {f12, rs1, f3, rd, op};
  endfunction

endpackage

FILE: rtl/rv32_instruction_encoder.sv
// Top level of the RV32IM instruction encoder: input register, encode logic, result register.
// An accepted word is held in the input register, passes the encode logic, and its first
// result is registered in the result register before it appears on the ports.
// Throughput: one word per cycle while busy is low; li with a large value and lw from a symbol give two
// results on consecutive cycles, and busy is high for the one cycle that costs.
// The receiver cannot stall: every result is shown with strobe for exactly one cycle.
// Reset (rst, synchronous, active high) empties the input and result stages.
module rv32_instruction_encoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [5:0]          kind,
  input  logic [4:0]          dest_reg,
  input  logic [4:0]          src1_reg,
  input  logic [4:0]          src2_reg,
  input  logic signed [32:0]  immediate,
  input  logic                is_symbol,
  input  logic [31:0]         pc,
  output logic                strobe,
  output logic [31:0]         machine_word,
  output logic                error,
  output logic                last
);
  import rv32enc_pkg::*;

  // Input stage. The payload is held without reset; only the valid flag is cleared.
  logic               s1_valid;
  logic [5:0]         s1_kind;
  logic [4:0]         s1_rd;
  logic [4:0]         s1_rs1;
  logic [4:0]         s1_rs2;
  logic signed [32:0] s1_imm;
  logic               s1_sym;
  logic [31:0]        s1_pc;

  // Second word of a two-word expansion, sent the cycle after the first.
  logic               pend_valid;
  logic [31:0]        pend_word;

  // Decode of pseudo forms onto a base instruction.
  kind_t              base;
  logic               base_ok;
  logic [4:0]         rd_e;
  logic [4:0]         rs1_e;
  logic [4:0]         rs2_e;
  logic signed [32:0] imm_e;
  logic               sym_e;
  row_t               row;

  // Range checks and encoded words.
  logic signed [33:0] imm34;
  logic signed [33:0] off;
  logic               in12;
  logic               in_sh;
  logic               in_u20;
  logic               in_br;
  logic               in_jal;
  logic               ok_b;
  logic [31:0]        word_b;
  logic [31:0]        u_val;
  logic [31:0]        u_round;
  logic [31:0]        rel;
  logic [31:0]        rel_round;
  logic               li_small;

  logic [31:0]        w1;
  logic [31:0]        w2;
  logic               enc_err;
  logic               two_word;

  // A new word is taken unless the held one expands into two results.
  assign busy = s1_valid && two_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    if (start && !busy) begin
      s1_kind <= kind;
      s1_rd   <= dest_reg;
      s1_rs1  <= src1_reg;
      s1_rs2  <= src2_reg;
      s1_imm  <= immediate;
      s1_sym  <= is_symbol;
      s1_pc   <= pc;
    end
  end

  // Map pseudo forms onto the base instruction they stand for. li and lw from a
  // symbol are built separately below because they may produce two words.
  always_comb begin
    base    = kind_t'(s1_kind);
    base_ok = 1'b1;
    rd_e    = s1_rd;
    rs1_e   = s1_rs1;
    rs2_e   = s1_rs2;
    imm_e   = s1_imm;
    sym_e   = s1_sym;
    case (kind_t'(s1_kind))
      K_BEQZ: begin
        base  = K_BEQ;
        rs2_e = REG_ZERO;
      end
      K_BNEZ: begin
        base  = K_BNE;
        rs2_e = REG_ZERO;
      end
      K_MV: begin
        base  = K_ADDI;
        imm_e = '0;
        sym_e = 1'b0;
      end
      K_J: begin
        base = K_JAL;
        rd_e = REG_ZERO;
      end
      K_JAL_RA: begin
        base = K_JAL;
        rd_e = REG_RA;
      end
      K_JR: begin
        base  = K_JALR;
        rd_e  = REG_ZERO;
        imm_e = '0;
        sym_e = 1'b0;
      end
      K_JALR_RA: begin
        base  = K_JALR;
        rd_e  = REG_RA;
        imm_e = '0;
        sym_e = 1'b0;
      end
      K_LI, K_LW_SYM: begin
        base_ok = 1'b0;
      end
      default: begin
        base_ok = (s1_kind inside {[K_ADD:K_JAL]});
      end
    endcase
  end

  assign row    = row_of(base);
  assign imm34  = {imm_e[32], imm_e};
  // Branch and jump targets given as a label are made relative to pc.
  assign off    = sym_e ? (imm34 - $signed({2'b00, s1_pc})) : imm34;
  assign in12   = (imm34 >= -34'sd2048) && (imm34 <= 34'sd2047);
  assign in_sh  = (imm34 >= 34'sd0) && (imm34 <= 34'sd31);
  assign in_u20 = (imm34 >= 34'sd0) && (imm34 <= 34'sd1048575);
  assign in_br  = (off >= -34'sd4096) && (off <= 34'sd4095);
  assign in_jal = (off >= -34'sd1048576) && (off <= 34'sd1048575);

  // Base instruction encoding by format.
  always_comb begin
    ok_b   = 1'b1;
    word_b = '0;
    case (row.cls)
      CL_R: begin
        word_b = {row.f7, rs2_e, rs1_e, row.f3, rd_e, row.op};
      end
      CL_IA: begin
        // A label here uses its low twelve bits without a range check.
        ok_b   = sym_e || in12;
        word_b = i_word(imm_e[11:0], rs1_e, row.f3, rd_e, row.op);
      end
      CL_ILW: begin
        ok_b   = in12;
        word_b = i_word(imm_e[11:0], rs1_e, row.f3, rd_e, row.op);
      end
      CL_ISH: begin
        ok_b   = !sym_e && in_sh;
        word_b = i_word({row.f7, imm_e[4:0]}, rs1_e, row.f3, rd_e, row.op);
      end
      CL_SYS: begin
        word_b = i_word({5'd0, row.f7}, REG_ZERO, 3'd0, REG_ZERO, row.op);
      end
      CL_S: begin
        ok_b   = !sym_e && in12;
        word_b = {imm_e[11:5], rs2_e, rs1_e, row.f3, imm_e[4:0], row.op};
      end
      CL_B: begin
        ok_b   = in_br;
        word_b = {off[12], off[10:5], rs2_e, rs1_e, row.f3, off[4:1], off[11], row.op};
      end
      CL_U: begin
        ok_b   = in_u20;
        word_b = {imm_e[19:0], rd_e, row.op};
      end
      CL_J: begin
        ok_b   = in_jal;
        word_b = {off[20], off[10:1], off[11], off[19:12], rd_e, row.op};
      end
      default: begin
        ok_b   = 1'b0;
        word_b = '0;
      end
    endcase
  end

  // li: one addi when the value fits twelve signed bits, else lui then addi.
  // lw from a symbol: auipc then lw, both on the pc-relative offset.
  assign u_val     = s1_imm[31:0];
  assign u_round   = u_val + HI_ROUND;
  assign li_small  = (u_val < 32'h0000_0800) || (u_val >= 32'hFFFF_F800);
  assign rel       = s1_imm[31:0] - s1_pc;
  assign rel_round = rel + HI_ROUND;

  always_comb begin
    w1       = '0;
    w2       = '0;
    enc_err  = 1'b0;
    two_word = 1'b0;
    case (kind_t'(s1_kind))
      K_LI: begin
        enc_err = s1_sym || (s1_imm < -33'sd2147483648);
        if (li_small) begin
          w1 = i_word(u_val[11:0], REG_ZERO, 3'd0, s1_rd, OP_IMM);
        end else begin
          w1 = {u_round[31:12], s1_rd, OP_LUI};
          w2 = i_word(u_val[11:0], s1_rd, 3'd0, s1_rd, OP_IMM);
        end
        two_word = !enc_err && !li_small;
      end
      K_LW_SYM: begin
        enc_err  = !s1_sym;
        w1       = {rel_round[31:12], s1_rd, OP_AUIPC};
        w2       = i_word(rel[11:0], s1_rd, 3'd2, s1_rd, OP_LOAD);
        two_word = s1_sym;
      end
      default: begin
        enc_err = !(base_ok && ok_b);
        w1      = word_b;
      end
    endcase
    // A failed check gives one result with a zero word.
    if (enc_err) begin
      w1 = '0;
    end
  end

  // Result register. The second word of an expansion has priority; no new word
  // can be in the input stage at the same time because busy held it off.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      strobe     <= pend_valid || s1_valid;
      pend_valid <= !pend_valid && s1_valid && two_word;
    end
    if (pend_valid) begin
      machine_word <= pend_word;
      error        <= 1'b0;
      last         <= 1'b1;
    end else begin
      machine_word <= w1;
      error        <= enc_err;
      last         <= !two_word;
    end
    if (s1_valid && two_word) begin
      pend_word <= w2;
    end
  end

`ifndef SYNTHESIS
  // A first word that is not last is always followed by its second word.
  a_second_word: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> (strobe && last && !error))
    else $error("second word of a two-word expansion missing");

  // An error result is a single zero word.
  a_error_word: assert property (@(posedge clk) disable iff (rst)
    (strobe && error) |-> (machine_word == 32'd0 && last))
    else $error("error result with nonzero word or not last");

  // Busy lasts exactly one cycle per two-word expansion.
  a_busy_short: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  // Every accepted word gives a strobed first result after the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 strobe)
    else $error("accepted word produced no result");
`endif

endmodule
